@@ rtl/xray_exposure_sequencer_defines.svh @@
// ----------------------------------------------------------------------------
// X-ray exposure sequencer assertion macros
// Shared property forms for the checker of the exposure sequencer.
// ----------------------------------------------------------------------------
`ifndef XRAY_EXPOSURE_SEQUENCER_DEFINES_SVH
`define XRAY_EXPOSURE_SEQUENCER_DEFINES_SVH

// same-cycle implication, off while reset is held
`define XES_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("xray_exposure_sequencer check failed");

// next-cycle implication, off while reset is held
`define XES_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("xray_exposure_sequencer check failed");

`endif

@@ rtl/xes_pkg.sv @@
// ----------------------------------------------------------------------------
// X-ray exposure sequencer package
// Shared types, widths and codes of the exposure sequencer.
// ----------------------------------------------------------------------------
package xes_pkg;

    localparam int KV_W       = 11;
    localparam int CUR_W      = 15;
    localparam int TIME_W     = 16;
    localparam int MAS_W      = 21;
    localparam int REQ_W      = 3;
    localparam int FOCUS_W    = 2;
    localparam int PROD_W     = CUR_W + TIME_W;
    localparam int RECIP_W    = 32;
    localparam int FULL_W     = PROD_W + RECIP_W;
    localparam int RECIP_SH   = 41;
    localparam int QUOT_W     = FULL_W - RECIP_SH;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    // ceil(2^41 / 1000): exact quotient for every product below 2^31
    localparam logic [RECIP_W-1:0] MAS_RECIP = 32'd2199023256;
    localparam logic [MAS_W-1:0]   MAS_LIMIT = {MAS_W{1'b1}};

    localparam logic [REQ_W-1:0] REQ_SET   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_START = 3'd1;
    localparam logic [REQ_W-1:0] REQ_ABORT = 3'd2;
    localparam logic [REQ_W-1:0] REQ_TICK  = 3'd3;

    localparam logic [FOCUS_W-1:0] FOCUS_UNKNOWN = 2'd3;

    localparam logic [CFG_ADDR_W-1:0] REG_KV_MIN     = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_KV_MAX     = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_CUR_MIN    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_CUR_MAX    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_TIME_MIN   = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_TIME_MAX   = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_AEC        = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_DUAL_FOCUS = 3'd7;

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_READY    = 2'd1,
        PH_ARMED    = 2'd2,
        PH_EXPOSING = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        ERR_NONE    = 2'd0,
        ERR_INVALID = 2'd1,
        ERR_NOT_SET = 2'd2,
        ERR_STATE   = 2'd3
    } err_t;

    typedef enum logic [2:0] {
        CMD_SET_OK,
        CMD_SET_BAD,
        CMD_START,
        CMD_ABORT,
        CMD_TICK,
        CMD_QUERY
    } cmd_kind_t;

    typedef struct packed {
        logic [KV_W-1:0]   kv_min;
        logic [KV_W-1:0]   kv_max;
        logic [CUR_W-1:0]  current_min;
        logic [CUR_W-1:0]  current_max;
        logic [TIME_W-1:0] time_min;
        logic [TIME_W-1:0] time_max;
        logic              aec_present;
        logic              dual_focus_present;
    } cfg_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic [KV_W-1:0]   kv;
        logic [CUR_W-1:0]  current;
        logic [TIME_W-1:0] exp_time;
        logic [MAS_W-1:0]  mas;
    } cmd_t;

    typedef struct packed {
        logic              accepted;
        err_t              error_code;
        phase_t            gen_state;
        logic [KV_W-1:0]   actual_kv;
        logic [CUR_W-1:0]  actual_current;
        logic [TIME_W-1:0] exposure_time;
        logic [MAS_W-1:0]  mas_tenths;
        logic              status_event;
    } res_t;

endpackage

@@ rtl/xray_exposure_sequencer.sv @@
// ----------------------------------------------------------------------------
// X-ray exposure sequencer
// Exposure control for an X-ray generator: set, start, abort, tick, query.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_ channel (valid/ready), one result per request
//   leaves on the m_ channel (valid/ready). Limits are written through
//   cfg_we/cfg_addr/cfg_wdata while no request is in flight.
//   The accepting edge loads the check stage (with the 15x16 current-time
//   multiply); the mAs stage (multiply by the reciprocal of 1000), the
//   command queue and the state machine's result register follow in that
//   order, and m_valid rises when the result register is loaded.
//   Throughput: one request per cycle while the receiver keeps m_ready
//   high; the back end updates its state as each request is popped.
//   Reset (aresetn low, synchronous) empties the pipeline and queue, sets the
//   phase to idle, forgets stored parameters and restores default limits.
//   When the receiver holds m_ready low, the result stays in place, the
//   queue fills, and s_ready falls once the front stages are full.
// ----------------------------------------------------------------------------
module xray_exposure_sequencer #(
    parameter int QUEUE_DEPTH = xes_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [xes_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [xes_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [xes_pkg::REQ_W-1:0]      s_req_type,
    input  logic [xes_pkg::KV_W-1:0]       s_kv_req,
    input  logic [xes_pkg::CUR_W-1:0]      s_current_req,
    input  logic [xes_pkg::TIME_W-1:0]     s_time_req,
    input  logic [xes_pkg::FOCUS_W-1:0]    s_focus_req,
    input  logic                           s_aec_auto_req,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_accepted,
    output logic [1:0]                     m_error_code,
    output logic [1:0]                     m_gen_state,
    output logic [xes_pkg::KV_W-1:0]       m_actual_kv,
    output logic [xes_pkg::CUR_W-1:0]      m_actual_current,
    output logic [xes_pkg::TIME_W-1:0]     m_exposure_time,
    output logic [xes_pkg::MAS_W-1:0]      m_mas_tenths,
    output logic                           m_status_event
);
    import xes_pkg::*;

    cfg_t cfg_reg;
    logic f_valid, f_ready, q_valid, q_ready;
    cmd_t f_cmd, q_cmd;
    res_t res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.kv_min             <= KV_W'(400);
            cfg_reg.kv_max             <= KV_W'(1500);
            cfg_reg.current_min        <= CUR_W'(10);
            cfg_reg.current_max        <= CUR_W'(5000);
            cfg_reg.time_min           <= TIME_W'(1);
            cfg_reg.time_max           <= TIME_W'(10000);
            cfg_reg.aec_present        <= 1'b0;
            cfg_reg.dual_focus_present <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_KV_MIN:     cfg_reg.kv_min             <= cfg_wdata[KV_W-1:0];
                REG_KV_MAX:     cfg_reg.kv_max             <= cfg_wdata[KV_W-1:0];
                REG_CUR_MIN:    cfg_reg.current_min        <= cfg_wdata[CUR_W-1:0];
                REG_CUR_MAX:    cfg_reg.current_max        <= cfg_wdata[CUR_W-1:0];
                REG_TIME_MIN:   cfg_reg.time_min           <= cfg_wdata[TIME_W-1:0];
                REG_TIME_MAX:   cfg_reg.time_max           <= cfg_wdata[TIME_W-1:0];
                REG_AEC:        cfg_reg.aec_present        <= cfg_wdata[0];
                REG_DUAL_FOCUS: cfg_reg.dual_focus_present <= cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    xes_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg_reg),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_kv_req       (s_kv_req),
        .s_current_req  (s_current_req),
        .s_time_req     (s_time_req),
        .s_focus_req    (s_focus_req),
        .s_aec_auto_req (s_aec_auto_req),
        .cmd_valid      (f_valid),
        .cmd_ready      (f_ready),
        .cmd            (f_cmd)
    );

    xes_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  (f_cmd),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_cmd)
    );

    xes_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (q_valid),
        .cmd_ready (q_ready),
        .cmd       (q_cmd),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .res       (res)
    );

    assign m_accepted       = res.accepted;
    assign m_error_code     = res.error_code;
    assign m_gen_state      = res.gen_state;
    assign m_actual_kv      = res.actual_kv;
    assign m_actual_current = res.actual_current;
    assign m_exposure_time  = res.exposure_time;
    assign m_mas_tenths     = res.mas_tenths;
    assign m_status_event   = res.status_event;

endmodule

@@ rtl/xes_front.sv @@
// ----------------------------------------------------------------------------
// X-ray exposure sequencer front end
// Accepts requests, range-checks set parameters and precomputes mAs.
// ----------------------------------------------------------------------------
module xes_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  xes_pkg::cfg_t               cfg,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [xes_pkg::REQ_W-1:0]   s_req_type,
    input  logic [xes_pkg::KV_W-1:0]    s_kv_req,
    input  logic [xes_pkg::CUR_W-1:0]   s_current_req,
    input  logic [xes_pkg::TIME_W-1:0]  s_time_req,
    input  logic [xes_pkg::FOCUS_W-1:0] s_focus_req,
    input  logic                        s_aec_auto_req,
    output logic                        cmd_valid,
    input  logic                        cmd_ready,
    output xes_pkg::cmd_t               cmd
);
    import xes_pkg::*;

    logic              s1_valid_reg;
    cmd_kind_t         s1_kind_reg, s1_kind_next;
    logic [KV_W-1:0]   s1_kv_reg;
    logic [CUR_W-1:0]  s1_cur_reg;
    logic [TIME_W-1:0] s1_time_reg;
    logic [PROD_W-1:0] s1_prod_reg;
    logic              s2_valid_reg;
    cmd_t              s2_cmd_reg, s2_cmd_next;
    logic              s1_advance, s2_advance, params_ok;
    logic [FULL_W-1:0] full_prod;
    logic [QUOT_W-1:0] quot;

    assign s2_advance = !s2_valid_reg || cmd_ready;
    assign s1_advance = !s1_valid_reg || s2_advance;
    assign s_ready    = s1_advance;
    assign cmd_valid  = s2_valid_reg;
    assign cmd        = s2_cmd_reg;

    always_comb begin
        params_ok = (s_kv_req >= cfg.kv_min) && (s_kv_req <= cfg.kv_max)
                 && (s_current_req >= cfg.current_min) && (s_current_req <= cfg.current_max)
                 && (s_time_req >= cfg.time_min) && (s_time_req <= cfg.time_max)
                 && !(cfg.dual_focus_present && (s_focus_req == FOCUS_UNKNOWN))
                 && !(s_aec_auto_req && !cfg.aec_present);
        unique case (s_req_type)
            REQ_SET:   s1_kind_next = params_ok ? CMD_SET_OK : CMD_SET_BAD;
            REQ_START: s1_kind_next = CMD_START;
            REQ_ABORT: s1_kind_next = CMD_ABORT;
            REQ_TICK:  s1_kind_next = CMD_TICK;
            default:   s1_kind_next = CMD_QUERY;
        endcase
    end

    always_comb begin
        full_prod = FULL_W'(s1_prod_reg) * FULL_W'(MAS_RECIP);
        quot      = full_prod[FULL_W-1:RECIP_SH];
        s2_cmd_next.kind     = s1_kind_reg;
        s2_cmd_next.kv       = s1_kv_reg;
        s2_cmd_next.current  = s1_cur_reg;
        s2_cmd_next.exp_time = s1_time_reg;
        s2_cmd_next.mas      = (quot > QUOT_W'(MAS_LIMIT)) ? MAS_LIMIT : quot[MAS_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            if (s1_advance) begin
                s1_valid_reg <= s_valid;
            end
            if (s2_advance) begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_advance && s_valid) begin
            s1_kind_reg <= s1_kind_next;
            s1_kv_reg   <= s_kv_req;
            s1_cur_reg  <= s_current_req;
            s1_time_reg <= s_time_req;
            s1_prod_reg <= PROD_W'(s_current_req) * PROD_W'(s_time_req);
        end
        if (s2_advance && s1_valid_reg) begin
            s2_cmd_reg <= s2_cmd_next;
        end
    end

endmodule

@@ rtl/xes_fifo.sv @@
// ----------------------------------------------------------------------------
// X-ray exposure sequencer command queue
// Short queue of classified requests between front and back end.
// ----------------------------------------------------------------------------
module xes_fifo #(
    parameter int DEPTH = xes_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push_valid,
    output logic          push_ready,
    input  xes_pkg::cmd_t push_data,
    output logic          pop_valid,
    input  logic          pop_ready,
    output xes_pkg::cmd_t pop_data
);
    import xes_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_data   = mem[rd_ptr_reg];

    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wrap_inc(wr_ptr_reg);
            end
            if (do_pop) begin
                rd_ptr_reg <= wrap_inc(rd_ptr_reg);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ rtl/xes_back.sv @@
// ----------------------------------------------------------------------------
// X-ray exposure sequencer back end
// Runs the exposure state machine and registers one result per request.
// ----------------------------------------------------------------------------
module xes_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  xes_pkg::cmd_t cmd,
    output logic          m_valid,
    input  logic          m_ready,
    output xes_pkg::res_t res
);
    import xes_pkg::*;

    phase_t            phase_reg, phase_next;
    logic              params_valid_reg, params_valid_next;
    logic [KV_W-1:0]   stored_kv_reg, stored_kv_next;
    logic [CUR_W-1:0]  stored_cur_reg, stored_cur_next;
    logic [TIME_W-1:0] stored_time_reg, stored_time_next;
    logic [MAS_W-1:0]  stored_mas_reg, stored_mas_next;
    logic [TIME_W-1:0] remaining_reg, remaining_next;
    logic [KV_W-1:0]   applied_kv_reg, applied_kv_next;
    logic [CUR_W-1:0]  applied_cur_reg, applied_cur_next;
    logic              m_valid_reg;
    res_t              res_reg, res_next;
    logic              pop, start_ok, abort_ok, tick_end;

    assign cmd_ready = !m_valid_reg || m_ready;
    assign pop       = cmd_valid && cmd_ready;
    assign m_valid   = m_valid_reg;
    assign res       = res_reg;

    assign start_ok = params_valid_reg && (phase_reg == PH_READY);
    assign abort_ok = (phase_reg == PH_ARMED) || (phase_reg == PH_EXPOSING);
    assign tick_end = (phase_reg == PH_EXPOSING) && (remaining_reg <= TIME_W'(1));

    // next state
    always_comb begin
        phase_next        = phase_reg;
        params_valid_next = params_valid_reg;
        stored_kv_next    = stored_kv_reg;
        stored_cur_next   = stored_cur_reg;
        stored_time_next  = stored_time_reg;
        stored_mas_next   = stored_mas_reg;
        remaining_next    = remaining_reg;
        applied_kv_next   = applied_kv_reg;
        applied_cur_next  = applied_cur_reg;
        if (pop) begin
            unique case (cmd.kind)
                CMD_SET_OK: begin
                    stored_kv_next    = cmd.kv;
                    stored_cur_next   = cmd.current;
                    stored_time_next  = cmd.exp_time;
                    stored_mas_next   = cmd.mas;
                    params_valid_next = 1'b1;
                    if (phase_reg == PH_IDLE) begin
                        phase_next = PH_READY;
                    end
                end
                CMD_START: begin
                    if (start_ok) begin
                        phase_next       = PH_EXPOSING;
                        applied_kv_next  = stored_kv_reg;
                        applied_cur_next = stored_cur_reg;
                        remaining_next   = stored_time_reg;
                    end
                end
                CMD_ABORT: begin
                    if (abort_ok) begin
                        phase_next = PH_IDLE;
                    end
                end
                CMD_TICK: begin
                    if (tick_end) begin
                        phase_next = PH_IDLE;
                    end else if (phase_reg == PH_EXPOSING) begin
                        remaining_next = remaining_reg - TIME_W'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // result
    always_comb begin
        res_next                = '0;
        res_next.accepted       = 1'b1;
        res_next.error_code     = ERR_NONE;
        res_next.gen_state      = phase_next;
        unique case (cmd.kind)
            CMD_SET_BAD: begin
                res_next.accepted   = 1'b0;
                res_next.error_code = ERR_INVALID;
            end
            CMD_START: begin
                if (!params_valid_reg) begin
                    res_next.accepted   = 1'b0;
                    res_next.error_code = ERR_NOT_SET;
                end else if (phase_reg != PH_READY) begin
                    res_next.accepted   = 1'b0;
                    res_next.error_code = ERR_STATE;
                end else begin
                    res_next.exposure_time = stored_time_reg;
                    res_next.mas_tenths    = stored_mas_reg;
                    res_next.status_event  = 1'b1;
                end
            end
            CMD_ABORT: res_next.status_event = abort_ok;
            CMD_TICK:  res_next.status_event = tick_end;
            default: begin
            end
        endcase
        if (phase_next == PH_EXPOSING) begin
            res_next.actual_kv      = applied_kv_next;
            res_next.actual_current = applied_cur_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_IDLE;
            params_valid_reg <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            phase_reg        <= phase_next;
            params_valid_reg <= params_valid_next;
            if (cmd_ready) begin
                m_valid_reg <= cmd_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        stored_kv_reg   <= stored_kv_next;
        stored_cur_reg  <= stored_cur_next;
        stored_time_reg <= stored_time_next;
        stored_mas_reg  <= stored_mas_next;
        remaining_reg   <= remaining_next;
        applied_kv_reg  <= applied_kv_next;
        applied_cur_reg <= applied_cur_next;
        if (pop) begin
            res_reg <= res_next;
        end
    end

endmodule

@@ rtl/xes_checker.sv @@
// ----------------------------------------------------------------------------
// X-ray exposure sequencer checker
// Port-level properties of the exposure sequencer, bound to the top level.
// ----------------------------------------------------------------------------
`include "xray_exposure_sequencer_defines.svh"

module xes_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic                           m_accepted,
    input logic [1:0]                     m_error_code,
    input logic [1:0]                     m_gen_state,
    input logic [xes_pkg::KV_W-1:0]       m_actual_kv,
    input logic [xes_pkg::CUR_W-1:0]      m_actual_current,
    input logic [xes_pkg::TIME_W-1:0]     m_exposure_time,
    input logic [xes_pkg::MAS_W-1:0]      m_mas_tenths,
    input logic                           m_status_event
);
    import xes_pkg::*;

    `XES_ASSERT_NEXT(a_hold_result, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_gen_state))
    `XES_ASSERT_NOW(a_off_when_idle, aclk, aresetn, m_valid && (m_gen_state != PH_EXPOSING), (m_actual_kv == '0) && (m_actual_current == '0))
    `XES_ASSERT_NOW(a_mas_on_start, aclk, aresetn, m_valid && (m_mas_tenths != '0), m_accepted && m_status_event && (m_gen_state == PH_EXPOSING) && (m_exposure_time != '0))
    `XES_ASSERT_NOW(a_refusal_coded, aclk, aresetn, m_valid && !m_accepted, (m_error_code != ERR_NONE) && !m_status_event)

endmodule

bind xray_exposure_sequencer xes_checker u_xes_checker (.*);
